>>> rtl/core/bant_pkg.sv
`default_nettype none

package bant_pkg;

  // table size and derived widths
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W = 16;
  localparam int PAIR_W = 2 * ADDR_W;

  // frame direction codes
  localparam logic KIND_SENT = 1'b0;
  localparam logic KIND_RECV = 1'b1;

  typedef struct packed {
    logic              kind;
    logic              is_data_frame;
    logic              individual_dest;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
  } in_item_t;

  typedef struct packed {
    logic              forwarded;
    logic [ADDR_W-1:0] out_src_addr;
    logic [ADDR_W-1:0] out_dst_addr;
    logic              lookup_hit;
    logic              table_full;
  } out_item_t;

  // stored pair: destination in the upper half, real source in the lower half
  typedef struct packed {
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
  } pair_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_t;

endpackage : bant_pkg

`default_nettype wire

>>> rtl/core/bant_ram.sv
`default_nettype none

module bant_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule : bant_ram

`default_nettype wire

>>> rtl/core/bus_address_nat_table.sv
`default_nettype none

// Address translator for a 16-bit individual-address field bus.
// Input: a frame descriptor on in_item is taken at a clock edge where start
// is high and busy is low. busy stays high until out_valid rises and is low
// in the cycle in which the result is shown.
// Output: exactly one result per frame on out_item, marked by out_valid for
// a single cycle; the receiver must take it, there is no back-pressure.
// Configuration: own_address is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high, writes belong in idle periods.
// Timing: a frame that needs no table search passes from the start transfer
// through the response state to out_valid. A search reads the pair table one
// entry per cycle from the RAM with one write port and a registered read
// port; the next start can be taken in the out_valid cycle.
// Write-back of a new or updated pair happens in the cycle before out_valid.
// Reset (rst_n low, synchronous) empties the table by clearing the pair
// count and sets own_address to 0; no clearing pass is needed.
module bus_address_nat_table
  import bant_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_item,
  output logic                   out_valid,
  output out_item_t              out_item,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [ADDR_W-1:0] cfg_data
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic              drop_r, drop_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic [CNT_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              hit_r, hit_nxt;
  logic [CNT_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [ADDR_W-1:0] hit_src_r, hit_src_nxt;
  logic [ADDR_W-1:0] own_addr_r;
  logic              out_valid_r;
  out_item_t         out_item_r, out_item_nxt;

  logic              accept;
  logic              need_search;
  logic [ADDR_W-1:0] key;
  logic              learn;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  pair_t             ram_wdata;
  pair_t             ram_rdata;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // search key: destination for sent frames, sender for received frames
  assign key = (item_r.kind == KIND_SENT) ? item_r.dst_addr : item_r.src_addr;

  // sent individual data frame learns its pair
  assign learn = (item_r.kind == KIND_SENT) && item_r.is_data_frame &&
                 item_r.individual_dest;

  // pair table
  bant_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_pair_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // write-back of the pair in the response state
  always_comb begin
    ram_we    = (state_r == ST_RESP) && learn && (hit_r || (count_r < FULL_CNT));
    ram_waddr = hit_r ? hit_idx_r[IDX_W-1:0] : count_r[IDX_W-1:0];
    ram_wdata = '{dst: item_r.dst_addr, src: item_r.src_addr};
  end

  // sequencer: accept, scan the table, respond
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    drop_nxt      = drop_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_valid_nxt = cmp_valid_r;
    cmp_idx_nxt   = cmp_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_src_nxt   = hit_src_r;
    need_search   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt      = in_item;
          drop_nxt      = (in_item.kind == KIND_RECV) && (in_item.src_addr == own_addr_r);
          hit_nxt       = 1'b0;
          scan_idx_nxt  = '0;
          cmp_valid_nxt = 1'b0;
          need_search   = in_item.individual_dest &&
                          (((in_item.kind == KIND_SENT) && in_item.is_data_frame) ||
                           ((in_item.kind == KIND_RECV) &&
                            (in_item.src_addr != own_addr_r)));
          state_nxt     = (need_search && (count_r != '0)) ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (cmp_valid_r && (ram_rdata.dst == key)) begin
          hit_nxt       = 1'b1;
          hit_idx_nxt   = cmp_idx_r;
          hit_src_nxt   = ram_rdata.src;
          cmp_valid_nxt = 1'b0;
          state_nxt     = ST_RESP;
        end else if (scan_idx_r < count_r) begin
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = scan_idx_r;
          scan_idx_nxt  = scan_idx_r + CNT_W'(1);
        end else begin
          cmp_valid_nxt = 1'b0;
          state_nxt     = ST_RESP;
        end
      end
      ST_RESP: begin
        if (learn && !hit_r && (count_r < FULL_CNT)) begin
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result fields
  always_comb begin
    out_item_nxt.forwarded    = 1'b1;
    out_item_nxt.out_src_addr = item_r.src_addr;
    out_item_nxt.out_dst_addr = item_r.dst_addr;
    out_item_nxt.lookup_hit   = 1'b0;
    out_item_nxt.table_full   = 1'b0;
    if (item_r.kind == KIND_SENT) begin
      if (item_r.is_data_frame) begin
        out_item_nxt.out_src_addr = own_addr_r;
      end
      out_item_nxt.table_full = learn && !hit_r && (count_r == FULL_CNT);
    end else if (drop_r) begin
      out_item_nxt.forwarded    = 1'b0;
      out_item_nxt.out_src_addr = '0;
      out_item_nxt.out_dst_addr = '0;
    end else if (item_r.individual_dest) begin
      out_item_nxt.out_dst_addr = hit_r ? hit_src_r : '0;
      out_item_nxt.lookup_hit   = hit_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      own_addr_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= (state_r == ST_RESP);
      if (cfg_valid && cfg_ready) begin
        own_addr_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    drop_r     <= drop_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_src_r  <= hit_src_nxt;
    if (state_r == ST_RESP) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule : bus_address_nat_table

`default_nettype wire

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bant_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned FRAMES_PER_PHASE = 320;
  localparam int unsigned DRAIN_CYCLES = 25;

  // reference translation table with its own copy of own_address and the pairs
  class nat_table_model;
    logic [ADDR_W-1:0] own_addr;
    logic [ADDR_W-1:0] peer_dst [TABLE_ENTRIES];
    logic [ADDR_W-1:0] peer_src [TABLE_ENTRIES];
    int unsigned       peer_cnt;
    out_item_t         expected_frames [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      own_addr = '0;
      peer_cnt = 0;
      errors = 0;
      checked = 0;
    endfunction

    function int find_peer(logic [ADDR_W-1:0] addr);
      for (int i = 0; i < peer_cnt; i++) begin
        if (peer_dst[i] == addr) return i;
      end
      return -1;
    endfunction

    // translate one frame and update the pair table
    function out_item_t translate_frame(in_item_t f);
      out_item_t o;
      int pos;
      o.forwarded = 1'b1;
      o.out_src_addr = f.src_addr;
      o.out_dst_addr = f.dst_addr;
      o.lookup_hit = 1'b0;
      o.table_full = 1'b0;
      if (f.kind == KIND_SENT) begin
        if (f.is_data_frame) begin
          if (f.individual_dest) begin
            pos = find_peer(f.dst_addr);
            if (pos >= 0) begin
              peer_src[pos] = f.src_addr;
            end else if (peer_cnt < TABLE_ENTRIES) begin
              peer_dst[peer_cnt] = f.dst_addr;
              peer_src[peer_cnt] = f.src_addr;
              peer_cnt++;
            end else begin
              o.table_full = 1'b1;
            end
          end
          o.out_src_addr = own_addr;
        end
      end else if (f.src_addr == own_addr) begin
        // own frame echoed back: dropped
        o.forwarded = 1'b0;
        o.out_src_addr = '0;
        o.out_dst_addr = '0;
      end else if (f.individual_dest) begin
        pos = find_peer(f.src_addr);
        if (pos >= 0) begin
          o.out_dst_addr = peer_src[pos];
          o.lookup_hit = 1'b1;
        end else begin
          o.out_dst_addr = '0;
        end
      end
      return o;
    endfunction

    function void note_frame(in_item_t f);
      out_item_t exp_item;
      exp_item = translate_frame(f);
      expected_frames = {expected_frames, exp_item};
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    function void check_frame(out_item_t got);
      out_item_t exp_item;
      checked++;
      if (expected_frames.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d arrived with nothing outstanding", checked);
        return;
      end
      exp_item = expected_frames.pop_front();
      if (got !== exp_item) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d mismatch: exp fwd=%b src=%h dst=%h hit=%b full=%b",
                   checked, exp_item.forwarded, exp_item.out_src_addr,
                   exp_item.out_dst_addr, exp_item.lookup_hit, exp_item.table_full);
          $display("  got fwd=%b src=%h dst=%h hit=%b full=%b",
                   got.forwarded, got.out_src_addr, got.out_dst_addr,
                   got.lookup_hit, got.table_full);
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_item;
  logic              out_valid;
  out_item_t         out_item;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_data;

  nat_table_model sb;
  bit             gaps_on;
  int unsigned    cycles;

  bus_address_nat_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result transfers cannot be held off, so every strobe is taken
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_frame(out_item);
  end

  function automatic in_item_t mk_frame(logic kind, logic data, logic indiv,
                                        logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst);
    in_item_t f;
    f.kind = kind;
    f.is_data_frame = data;
    f.individual_dest = indiv;
    f.src_addr = src;
    f.dst_addr = dst;
    return f;
  endfunction

  function automatic logic [ADDR_W-1:0] known_peer();
    if (sb.peer_cnt == 0) return ADDR_W'($urandom_range(0, 65535));
    return sb.peer_dst[$urandom_range(0, sb.peer_cnt - 1)];
  endfunction

  // mostly frames that hit stored peers, the rest arbitrary
  function automatic in_item_t pick_frame();
    in_item_t    f;
    int unsigned r;
    f.kind = 1'($urandom_range(0, 1));
    f.is_data_frame = ($urandom_range(0, 99) < 85);
    f.individual_dest = ($urandom_range(0, 99) < 80);
    f.src_addr = ADDR_W'($urandom_range(0, 65535));
    f.dst_addr = ADDR_W'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (f.kind == KIND_SENT) begin
      if (r < 65) f.dst_addr = known_peer();
      else if (r < 70) f.src_addr = sb.own_addr;
    end else begin
      if (r < 10) f.src_addr = sb.own_addr;
      else if (r < 75) f.src_addr = known_peer();
    end
    return f;
  endfunction

  // one start transfer, with random gaps on the request while gaps_on is set
  task automatic send_frame(input in_item_t f);
    bit idle;
    in_item <= f;
    forever begin
      idle = gaps_on && ($urandom_range(0, 99) < 7);
      start <= !idle;
      @(posedge clk);
      if (start && !busy) break;
    end
    sb.note_frame(f);
  endtask

  // wait until every expected result is in and the block is idle
  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_own(input logic [ADDR_W-1:0] addr);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.own_addr = addr;
  endtask

  initial begin
    logic [ADDR_W-1:0] own_val;
    sb = new();
    gaps_on = 1'b1;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames
    write_own(16'h11A5);
    send_frame(mk_frame(KIND_SENT, 1'b0, 1'b1, 16'h1234, 16'hFFFF));
    send_frame(mk_frame(KIND_SENT, 1'b1, 1'b0, 16'h0000, 16'h0000));
    send_frame(mk_frame(KIND_SENT, 1'b1, 1'b1, 16'h0000, 16'hFFFF));
    send_frame(mk_frame(KIND_SENT, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
    send_frame(mk_frame(KIND_RECV, 1'b0, 1'b1, 16'hFFFF, 16'h0000));
    send_frame(mk_frame(KIND_RECV, 1'b1, 1'b1, 16'h2222, 16'hFFFF));
    send_frame(mk_frame(KIND_RECV, 1'b1, 1'b0, 16'h3333, 16'hFFFF));
    send_frame(mk_frame(KIND_RECV, 1'b0, 1'b1, 16'h11A5, 16'h5555));
    // fill the table up to its last entry
    for (int i = 0; i < 15; i++)
      send_frame(mk_frame(KIND_SENT, 1'b1, 1'b1, ~ADDR_W'(i * 16'h1111),
                          ADDR_W'(i * 16'h1111)));
    // full table: new peer refused, update of a known one still taken
    send_frame(mk_frame(KIND_SENT, 1'b1, 1'b1, 16'h0F0F, 16'h4242));
    send_frame(mk_frame(KIND_SENT, 1'b1, 1'b1, 16'hABCD, 16'h1111));
    send_frame(mk_frame(KIND_RECV, 1'b0, 1'b1, 16'h1111, 16'h0000));

    // random phases, each starting with a write of own address
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: own_val = 16'hFFFF;
        1: own_val = 16'h0000;
        default: own_val = ADDR_W'($urandom_range(0, 65535));
      endcase
      write_own(own_val);
      gaps_on = (p != 2);
      repeat (FRAMES_PER_PHASE) send_frame(pick_frame());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
